// ----- hw/rtl/hwt_pkg.sv -----
`timescale 1ns / 1ps

package hwt_pkg;

	localparam int SAMPLE_W = 8;
	localparam int INDEX_W  = 8;

	// Item mode codes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_FILL  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RED   = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_MIX   = 5'b10000
	} state_t;

	// Triangle wave value for an 8-bit phase.
	function automatic logic [SAMPLE_W-1:0] tri_value(input logic [7:0] p);
		logic [8:0] v;
		if (p < 8'd64) begin
			v = 9'd129 + {p, 1'b0};
		end else if (p < 8'd192) begin
			v = 9'd1 + {8'd191 - p, 1'b0};
		end else begin
			v = 9'd1 + {p - 8'd192, 1'b0};
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// Average of two offset-128 samples, halving toward zero.
	function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b);
		logic signed [9:0] s;
		logic signed [9:0] t;
		logic signed [9:0] h;
		s = $signed({2'b00, a}) + $signed({2'b00, b}) - 10'sd256;
		t = s + $signed({9'd0, s[9]});
		h = (t >>> 1) + 10'sd128;
		return h[SAMPLE_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/hwt_if.sv -----
`timescale 1ns / 1ps

interface hwt_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [hwt_pkg::INDEX_W-1:0]   sample_index;
	logic [hwt_pkg::SAMPLE_W-1:0]  base_sample;

	modport source(output valid, mode, sample_index, base_sample, input ready);
	modport sink(input valid, mode, sample_index, base_sample, output ready);
endinterface

interface hwt_out_if;
	logic                          valid;
	logic                          ready;
	logic [hwt_pkg::SAMPLE_W-1:0]  harmonic_sample;
	logic [hwt_pkg::INDEX_W-1:0]   read_index;

	modport source(output valid, harmonic_sample, read_index, input ready);
	modport sink(input valid, harmonic_sample, read_index, output ready);
endinterface

// ----- hw/rtl/hwt_ram.sv -----
`timescale 1ns / 1ps

module hwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- hw/rtl/hwt_modadd.sv -----
`timescale 1ns / 1ps

// Adds two operands and folds the sum back once below the modulus.
// Both operands stay below 2**(WIDTH-1), so one subtraction is enough
// whenever both are already reduced.
module hwt_modadd #(
	parameter int WIDTH   = 9,
	parameter int MODULUS = 256
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic [WIDTH-1:0] y,
	output logic             wrap
);

	localparam logic [WIDTH-1:0] MOD_W = WIDTH'(MODULUS);

	logic [WIDTH-1:0] sum;

	always_comb begin
		sum  = a + b;
		wrap = (sum >= MOD_W);
		y    = wrap ? (sum - MOD_W) : sum;
	end

endmodule

// ----- hw/rtl/harmonic_wavetable.sv -----
`timescale 1ns / 1ps

// Harmonic wavetable. The block holds TABLE_SIZE unsigned offset-128 base
// samples in a single-port RAM. A write beat (mode 0) stores base_sample at
// sample_index modulo TABLE_SIZE and returns nothing. A read beat (mode 1) at
// index i returns blend(w[i], blend(w[2i], blend(w[3i], w[4i]))), all indices
// modulo TABLE_SIZE, where blend averages two offset-128 samples and rounds
// toward zero. After reset the block runs a fill pass over every entry
// that loads the triangle wave; it takes no beat until the pass is done.
// Sequence: a read goes through the index reduction, four RAM reads and
// three blend steps; a write goes through the index reduction alone. No new
// beat is accepted until the block is back in idle. When TABLE_SIZE is below
// 256 the index reduction subtracts TABLE_SIZE once per step until the index
// is below it. The single RAM port gives one table read per cycle, and
// one shared modular adder reduces indices and steps i, 2i, 3i, 4i.
// The result sits in an output register, so a waiting result only stalls
// the block when the next read is ready to be delivered.
module harmonic_wavetable #(
	parameter int TABLE_SIZE = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	hwt_in_if.sink     req,
	hwt_out_if.source  rsp
);

	localparam int AW = $clog2(TABLE_SIZE);
	// Adder width: room for an 8-bit index or a table address, plus a carry.
	localparam int UW = ((AW > hwt_pkg::INDEX_W) ? AW : hwt_pkg::INDEX_W) + 1;
	// Phase advance per table entry during the fill pass: 256 / TABLE_SIZE.
	localparam int PH_STEP = 256 / TABLE_SIZE;
	localparam int PH_REM  = 256 % TABLE_SIZE;

	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);

	hwt_pkg::state_t state_q;

	// Fill pass.
	logic [AW-1:0]  fill_q;
	logic [AW-1:0]  rem_q;
	logic [8:0]     ph_q;

	// Item being worked on.
	logic                           mode_q;
	logic [hwt_pkg::INDEX_W-1:0]    idx_q;
	logic [hwt_pkg::INDEX_W-1:0]    r_q;
	logic [hwt_pkg::SAMPLE_W-1:0]   sample_q;
	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  step_q;
	logic [1:0]                     cnt_q;
	logic [hwt_pkg::SAMPLE_W-1:0]   w_q [3];
	logic [hwt_pkg::SAMPLE_W-1:0]   acc_q;

	// Output register.
	logic                           out_valid_q;
	logic [hwt_pkg::SAMPLE_W-1:0]   out_sample_q;
	logic [hwt_pkg::INDEX_W-1:0]    out_index_q;

	// Shared modular adder.
	logic [UW-1:0] mod_a;
	logic [UW-1:0] mod_b;
	logic [UW-1:0] mod_y;
	logic          mod_wrap;

	// RAM port.
	logic                           ram_we;
	logic [AW-1:0]                  ram_addr;
	logic [hwt_pkg::SAMPLE_W-1:0]   ram_wdata;
	logic [hwt_pkg::SAMPLE_W-1:0]   ram_rdata;

	logic [UW-1:0]                  r_ext;
	logic [AW-1:0]                  r_addr;
	logic [hwt_pkg::SAMPLE_W-1:0]   mix_a;
	logic [hwt_pkg::SAMPLE_W-1:0]   mix_b;
	logic [hwt_pkg::SAMPLE_W-1:0]   mix_y;
	logic                           accept;
	logic                           red_done;
	logic                           out_load;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == hwt_pkg::ST_IDLE);

	assign r_ext    = UW'(r_q);
	assign r_addr   = r_ext[AW-1:0];
	assign red_done = (state_q == hwt_pkg::ST_RED) && !mod_wrap;

	// The adder serves the fill phase, the index reduction and the address
	// stepping, which never overlap.
	always_comb begin
		case (state_q)
			hwt_pkg::ST_FILL: begin
				mod_a = UW'(rem_q);
				mod_b = UW'(PH_REM);
			end
			hwt_pkg::ST_RED: begin
				mod_a = r_ext;
				mod_b = '0;
			end
			hwt_pkg::ST_FETCH: begin
				mod_a = UW'(addr_q);
				mod_b = UW'(step_q);
			end
			default: begin
				mod_a = '0;
				mod_b = '0;
			end
		endcase
	end

	hwt_modadd #(
		.WIDTH   (UW),
		.MODULUS (TABLE_SIZE)
	) u_modadd (
		.a    (mod_a),
		.b    (mod_b),
		.y    (mod_y),
		.wrap (mod_wrap)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = sample_q;
		if (state_q == hwt_pkg::ST_FILL) begin
			ram_we    = 1'b1;
			ram_addr  = fill_q;
			ram_wdata = hwt_pkg::tri_value(ph_q[7:0]);
		end else if (red_done && (mode_q == hwt_pkg::MODE_WRITE)) begin
			ram_we   = 1'b1;
			ram_addr = r_addr;
		end
	end

	hwt_ram #(
		.WIDTH (hwt_pkg::SAMPLE_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Blend chain: w3 with w4 (straight from the RAM), then w2, then w1.
	assign mix_a = w_q[2'd2 - cnt_q];
	assign mix_b = (cnt_q == 2'd0) ? ram_rdata : acc_q;
	assign mix_y = hwt_pkg::blend(mix_a, mix_b);

	assign out_load = (state_q == hwt_pkg::ST_MIX) && (cnt_q == 2'd2)
		&& (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hwt_pkg::ST_FILL;
			fill_q  <= '0;
			rem_q   <= '0;
			ph_q    <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				hwt_pkg::ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					rem_q  <= mod_y[AW-1:0];
					ph_q   <= ph_q + 9'(PH_STEP) + 9'(mod_wrap);
					if (fill_q == LAST_ADDR) begin
						state_q <= hwt_pkg::ST_IDLE;
					end
				end
				hwt_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= hwt_pkg::ST_RED;
					end
				end
				hwt_pkg::ST_RED: begin
					if (!mod_wrap) begin
						cnt_q <= '0;
						if (mode_q == hwt_pkg::MODE_WRITE) begin
							state_q <= hwt_pkg::ST_IDLE;
						end else begin
							state_q <= hwt_pkg::ST_FETCH;
						end
					end
				end
				hwt_pkg::ST_FETCH: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= hwt_pkg::ST_MIX;
					end
				end
				hwt_pkg::ST_MIX: begin
					if (cnt_q != 2'd2) begin
						cnt_q <= cnt_q + 2'd1;
					end else if (out_load) begin
						state_q <= hwt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= hwt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.mode;
			idx_q    <= req.sample_index;
			r_q      <= req.sample_index;
			sample_q <= req.base_sample;
		end
		if ((state_q == hwt_pkg::ST_RED) && mod_wrap) begin
			r_q <= mod_y[hwt_pkg::INDEX_W-1:0];
		end
		if (red_done) begin
			addr_q <= r_addr;
			step_q <= r_addr;
		end
		if (state_q == hwt_pkg::ST_FETCH) begin
			addr_q <= mod_y[AW-1:0];
			if (cnt_q != 2'd0) begin
				w_q[cnt_q - 2'd1] <= ram_rdata;
			end
		end
		if ((state_q == hwt_pkg::ST_MIX) && (cnt_q != 2'd2)) begin
			acc_q <= mix_y;
		end
		if (out_load) begin
			out_sample_q <= mix_y;
			out_index_q  <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.harmonic_sample = out_sample_q;
	assign rsp.read_index      = out_index_q;

	// A result beat only appears at the end of the blend sequence.
	a_result_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == hwt_pkg::ST_MIX))
		else $error("result appeared outside the blend sequence");

	// Every table read address is already reduced below the table size.
	a_fetch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwt_pkg::ST_FETCH) |-> ((UW'(addr_q)) < (UW'(TABLE_SIZE))))
		else $error("table read address out of range");

	// An accepted beat always starts with the index reduction.
	a_accept_to_red: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == hwt_pkg::ST_RED))
		else $error("accepted beat did not start index reduction");

	// The blend step counter never runs past its last step.
	a_mix_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwt_pkg::ST_MIX) |-> (cnt_q != 2'd3))
		else $error("blend step counter overran");

endmodule

// ----- tb/harmonic_wavetable_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the harmonic wavetable. A small tracker keeps a
// private copy of the 256-entry base wave and predicts each harmonic sample
// from it. Results are checked in order, and every field is compared.
module harmonic_wavetable_tb;

	localparam int CLK_PERIOD     = 4;
	localparam int TABLE_ENTRIES  = 256;
	localparam int BEATS_PER_MIX  = 358;
	localparam int SETTLE_CYCLES  = 32;

	// One predicted result: the harmonic sample and the index it belongs to.
	typedef struct packed {
		logic [hwt_pkg::SAMPLE_W-1:0] sample;
		logic [hwt_pkg::INDEX_W-1:0]  index;
	} harmonic_t;

	// The tracker mirrors the base wave and holds the harmonic samples that
	// have been predicted but not yet seen on the result channel.
	class harmonic_tracker;
		logic [hwt_pkg::SAMPLE_W-1:0] base_wave [TABLE_ENTRIES];
		harmonic_t                    pending_harmonics [$];
		int                           errors;
		int                           writes;
		int                           reads;
		int                           checked;

		function new();
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				base_wave[k] = triangle_at(k);
			end
			errors  = 0;
			writes  = 0;
			reads   = 0;
			checked = 0;
		endfunction

		// Power-up triangle: a rise from 129, a long fall, then a rise again.
		function logic [hwt_pkg::SAMPLE_W-1:0] triangle_at(int phase);
			int v;
			if (phase < 64) begin
				v = 129 + 2 * phase;
			end else if (phase < 192) begin
				v = 1 + 2 * (191 - phase);
			end else begin
				v = 1 + 2 * (phase - 192);
			end
			return hwt_pkg::SAMPLE_W'(v);
		endfunction

		// Average of two offset-128 samples; integer division rounds toward zero.
		function logic [hwt_pkg::SAMPLE_W-1:0] avg_offset(
			logic [hwt_pkg::SAMPLE_W-1:0] a, logic [hwt_pkg::SAMPLE_W-1:0] b);
			int sum;
			sum = (int'(a) - 128) + (int'(b) - 128);
			return hwt_pkg::SAMPLE_W'(sum / 2 + 128);
		endfunction

		function logic [hwt_pkg::SAMPLE_W-1:0] wave_at(int pos);
			return base_wave[pos % TABLE_ENTRIES];
		endfunction

		function void note_beat(logic mode, logic [hwt_pkg::INDEX_W-1:0] index,
			logic [hwt_pkg::SAMPLE_W-1:0] sample);
			harmonic_t h;
			int        i;
			i = int'(index);
			if (mode == hwt_pkg::MODE_WRITE) begin
				base_wave[i % TABLE_ENTRIES] = sample;
				writes++;
			end else begin
				h.sample = avg_offset(wave_at(i), avg_offset(wave_at(2 * i),
					avg_offset(wave_at(3 * i), wave_at(4 * i))));
				h.index  = index;
				pending_harmonics.push_back(h);
				reads++;
			end
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_harmonic(logic [hwt_pkg::SAMPLE_W-1:0] sample,
			logic [hwt_pkg::INDEX_W-1:0] index);
			harmonic_t want;
			if (pending_harmonics.size() == 0) begin
				report($sformatf("unexpected result sample=%0d index=%0d", sample, index));
			end else begin
				want = pending_harmonics.pop_front();
				checked++;
				if (sample !== want.sample) begin
					report($sformatf("harmonic_sample at index %0d: got %0d, want %0d",
						want.index, sample, want.sample));
				end
				if (index !== want.index) begin
					report($sformatf("read_index: got %0d, want %0d", index, want.index));
				end
			end
		endtask

		task check_drained();
			if (pending_harmonics.size() != 0) begin
				report($sformatf("%0d harmonic results never arrived",
					pending_harmonics.size()));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	hwt_in_if  req_if ();
	hwt_out_if rsp_if ();

	harmonic_wavetable #(
		.TABLE_SIZE(TABLE_ENTRIES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	harmonic_tracker tracker;

	// Percent of cycles in which the sender holds back or the receiver stalls.
	int src_idle_pct;
	int sink_stall_pct;

	// Index of the last random write, so that reads can go after fresh data.
	logic [hwt_pkg::INDEX_W-1:0] last_written;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// The receiver decides at each falling edge whether it takes a beat at the
	// next rising edge. It never takes anything while reset is held.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Every result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			tracker.check_harmonic(rsp_if.harmonic_sample, rsp_if.read_index);
		end
	end

	// Offers one beat and returns at the falling edge after it is accepted.
	// Called at a falling edge; valid is written once per edge, so a beat that
	// follows straight on keeps valid high without a glitch.
	task automatic send_beat(input logic mode, input logic [hwt_pkg::INDEX_W-1:0] index,
		input logic [hwt_pkg::SAMPLE_W-1:0] sample);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.mode         <= mode;
		req_if.sample_index <= index;
		req_if.base_sample  <= sample;
		@(posedge clk);
		while (req_if.ready !== 1'b1) begin
			@(posedge clk);
		end
		tracker.note_beat(mode, index, sample);
		@(negedge clk);
	endtask

	// Writes lean toward the extremes so that the blend sees full-scale sums of
	// both signs, including odd negative ones that must round toward zero.
	function automatic logic [hwt_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127 + 8'($urandom_range(0, 2));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Reads go mostly to random indices, but often to the last write or to an
	// index whose double or quadruple lands on it, so fresh data feeds every
	// stage of the blend chain.
	function automatic logic [hwt_pkg::INDEX_W-1:0] pick_read_index();
		case ($urandom_range(0, 7))
			0: return last_written;
			1: return last_written >> 1;
			2: return last_written >> 2;
			3: return 8'($urandom_range(0, 1) ? 0 : 255);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_mix(input int count, input int src_pct, input int sink_pct);
		logic [hwt_pkg::INDEX_W-1:0] index;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 45) begin
				index = 8'($urandom_range(0, 255));
				last_written = index;
				send_beat(hwt_pkg::MODE_WRITE, index, pick_sample());
			end else begin
				send_beat(hwt_pkg::MODE_READ, pick_read_index(),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		req_if.valid        = 1'b0;
		req_if.mode         = hwt_pkg::MODE_WRITE;
		req_if.sample_index = '0;
		req_if.base_sample  = '0;
		arst_n              = 1'b0;
		src_idle_pct        = 0;
		sink_stall_pct      = 0;
		last_written        = '0;
		tracker             = new();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, back to back. The block first loads its triangle and
		// holds off the first beat until then; the handshake covers that wait.
		// Reads of the power-up triangle at its corners and both ends.
		send_beat(hwt_pkg::MODE_READ, 8'd0,   8'd0);
		send_beat(hwt_pkg::MODE_READ, 8'd1,   8'd255);
		send_beat(hwt_pkg::MODE_READ, 8'd64,  8'd0);
		send_beat(hwt_pkg::MODE_READ, 8'd127, 8'd0);
		send_beat(hwt_pkg::MODE_READ, 8'd128, 8'd0);
		send_beat(hwt_pkg::MODE_READ, 8'd192, 8'd0);
		send_beat(hwt_pkg::MODE_READ, 8'd255, 8'd0);
		// Index zero reads one entry four times: full scale high, then low.
		send_beat(hwt_pkg::MODE_WRITE, 8'd0, 8'd255);
		send_beat(hwt_pkg::MODE_READ,  8'd0, 8'd0);
		send_beat(hwt_pkg::MODE_WRITE, 8'd0, 8'd0);
		send_beat(hwt_pkg::MODE_READ,  8'd0, 8'd0);
		send_beat(hwt_pkg::MODE_WRITE, 8'd0, 8'd1);
		send_beat(hwt_pkg::MODE_READ,  8'd0, 8'd0);
		// The top entry: its multiples wrap around the table.
		send_beat(hwt_pkg::MODE_WRITE, 8'd255, 8'd0);
		send_beat(hwt_pkg::MODE_READ,  8'd255, 8'd0);
		// Index 85 reaches 170, 255 and, after the wrap, 84. Mixed extremes
		// give odd negative sums that must round toward zero.
		send_beat(hwt_pkg::MODE_WRITE, 8'd85,  8'd0);
		send_beat(hwt_pkg::MODE_WRITE, 8'd170, 8'd255);
		send_beat(hwt_pkg::MODE_WRITE, 8'd84,  8'd1);
		send_beat(hwt_pkg::MODE_READ,  8'd85,  8'd0);
		// Index 64 reaches 128, 192 and wraps to zero.
		send_beat(hwt_pkg::MODE_WRITE, 8'd64,  8'd127);
		send_beat(hwt_pkg::MODE_WRITE, 8'd128, 8'd129);
		send_beat(hwt_pkg::MODE_WRITE, 8'd192, 8'd128);
		send_beat(hwt_pkg::MODE_READ,  8'd64,  8'd0);
		send_beat(hwt_pkg::MODE_READ,  8'd32,  8'd0);

		// Random part in four pressure settings: free flow, a slow sender, a
		// slow receiver, and both sides occasionally pausing.
		random_mix(BEATS_PER_MIX, 0,  0);
		random_mix(BEATS_PER_MIX, 64, 0);
		random_mix(BEATS_PER_MIX, 0,  64);
		random_mix(BEATS_PER_MIX, 16, 16);

		req_if.valid <= 1'b0;
		sink_stall_pct = 0;

		// Drain what is still in flight, then give the block a little longer
		// so that any stray extra result would show up.
		while (tracker.pending_harmonics.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		tracker.check_drained();

		$display("Sent %0d writes and %0d harmonic reads over four pressure settings.",
			tracker.writes, tracker.reads);
		$display("Checked %0d results, %0d mismatches.", tracker.checked, tracker.errors);
		if (tracker.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog: the slowest correct run is well under a tenth of this.
	initial begin
		#2_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/hwt_pkg.sv
hw/rtl/hwt_if.sv
hw/rtl/hwt_ram.sv
hw/rtl/hwt_modadd.sv
hw/rtl/harmonic_wavetable.sv
tb/harmonic_wavetable_tb.sv
